// ===== src/zps_pkg.sv =====
package zps_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned COST_W = 4;

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] OP_NOP      = 8'h00;
  localparam logic [7:0] OP_LD_BC_NN = 8'h01;
  localparam logic [7:0] OP_LD_IBC_A = 8'h02;
  localparam logic [7:0] OP_INC_BC   = 8'h03;
  localparam logic [7:0] OP_INC_B    = 8'h04;
  localparam logic [7:0] OP_DEC_B    = 8'h05;
  localparam logic [7:0] OP_LD_B_N   = 8'h06;
  localparam logic [7:0] OP_RLCA     = 8'h07;
  localparam logic [7:0] OP_EX_AF    = 8'h08;
  localparam logic [7:0] OP_ADD_HLBC = 8'h09;
  localparam logic [7:0] OP_LD_A_IBC = 8'h0a;
  localparam logic [7:0] OP_DEC_BC   = 8'h0b;
  localparam logic [7:0] OP_INC_C    = 8'h0c;
  localparam logic [7:0] OP_DEC_C    = 8'h0d;
  localparam logic [7:0] OP_LD_C_N   = 8'h0e;
  localparam logic [7:0] OP_RRCA     = 8'h0f;
  localparam logic [7:0] OP_LD_HL_NN = 8'h21;
  localparam logic [7:0] OP_LD_A_N   = 8'h3e;

  localparam logic [7:0] F_SZPV  = 8'hc4;
  localparam logic [7:0] F_SXY   = 8'ha8;
  localparam logic [7:0] F_XY    = 8'h28;
  localparam logic [7:0] F_Z     = 8'h40;
  localparam logic [7:0] F_H     = 8'h10;
  localparam logic [7:0] F_PV    = 8'h04;
  localparam logic [7:0] F_N     = 8'h02;
  localparam logic [7:0] F_C     = 8'h01;

  typedef enum logic [2:0] {
    CLS_SIMPLE,
    CLS_IMM8,
    CLS_IMM16,
    CLS_STORE,
    CLS_LOAD
  } zps_cls_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_OPND_LO,
    ST_OPND_LO_WB,
    ST_OPND_HI_WB,
    ST_STORE,
    ST_LOAD,
    ST_LOAD_WB,
    ST_MEM_WR,
    ST_MEM_RD,
    ST_MEM_RD_WB,
    ST_FINISH
  } zps_state_e;

  typedef struct packed {
    logic latch_in;
    logic rd_pc;
    logic exec;
    logic take_lo;
    logic take_hi;
    logic wr_bc;
    logic rd_bc;
    logic take_ld;
    logic wr_addr;
    logic rd_addr;
    logic take_rd;
    logic load_out;
  } zps_cmd_t;

  typedef struct packed {
    logic     halted;
    logic     out_free;
    zps_cls_e cls;
  } zps_sts_t;

  function automatic zps_cls_e op_class(input logic [7:0] op);
    zps_cls_e c;
    case (op)
      OP_LD_B_N, OP_LD_C_N, OP_LD_A_N: c = CLS_IMM8;
      OP_LD_BC_NN, OP_LD_HL_NN:        c = CLS_IMM16;
      OP_LD_IBC_A:                     c = CLS_STORE;
      OP_LD_A_IBC:                     c = CLS_LOAD;
      default:                         c = CLS_SIMPLE;
    endcase
    return c;
  endfunction

  function automatic logic [COST_W-1:0] op_cost(input logic [7:0] op);
    logic [COST_W-1:0] c;
    case (op)
      OP_LD_BC_NN, OP_LD_HL_NN:                         c = 4'd10;
      OP_LD_IBC_A, OP_LD_B_N, OP_LD_A_IBC, OP_LD_C_N,
      OP_LD_A_N:                                        c = 4'd7;
      OP_INC_BC, OP_DEC_BC:                             c = 4'd6;
      OP_ADD_HLBC:                                      c = 4'd11;
      default:                                          c = 4'd4;
    endcase
    return c;
  endfunction

endpackage

// ===== src/zps_ctrl.sv =====
module zps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       cmd_i,
  input  zps_pkg::zps_sts_t sts_i,
  output logic             in_stall_o,
  output zps_pkg::zps_cmd_t cmd_o
);

  zps_pkg::zps_state_e state_q, state_d;
  zps_pkg::zps_cls_e   cls_q, cls_d;
  logic                accept;

  assign accept     = in_valid_i && (state_q == zps_pkg::ST_IDLE);
  assign in_stall_o = (state_q != zps_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= zps_pkg::ST_IDLE;
      cls_q   <= zps_pkg::CLS_SIMPLE;
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cls_d   = cls_q;
    case (state_q)
      zps_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd_i == zps_pkg::CMD_EXEC && !sts_i.halted) begin
            state_d = zps_pkg::ST_FETCH;
          end else if (cmd_i == zps_pkg::CMD_WRITE) begin
            state_d = zps_pkg::ST_MEM_WR;
          end else if (cmd_i == zps_pkg::CMD_READ) begin
            state_d = zps_pkg::ST_MEM_RD;
          end else begin
            state_d = zps_pkg::ST_FINISH;
          end
        end
      end
      zps_pkg::ST_FETCH: state_d = zps_pkg::ST_DECODE;
      zps_pkg::ST_DECODE: begin
        cls_d = sts_i.cls;
        case (sts_i.cls)
          zps_pkg::CLS_IMM8, zps_pkg::CLS_IMM16: state_d = zps_pkg::ST_OPND_LO;
          zps_pkg::CLS_STORE:                    state_d = zps_pkg::ST_STORE;
          zps_pkg::CLS_LOAD:                     state_d = zps_pkg::ST_LOAD;
          default:                               state_d = zps_pkg::ST_FINISH;
        endcase
      end
      zps_pkg::ST_OPND_LO: state_d = zps_pkg::ST_OPND_LO_WB;
      zps_pkg::ST_OPND_LO_WB: begin
        if (cls_q == zps_pkg::CLS_IMM16) begin
          state_d = zps_pkg::ST_OPND_HI_WB;
        end else begin
          state_d = zps_pkg::ST_FINISH;
        end
      end
      zps_pkg::ST_OPND_HI_WB: state_d = zps_pkg::ST_FINISH;
      zps_pkg::ST_STORE:      state_d = zps_pkg::ST_FINISH;
      zps_pkg::ST_LOAD:       state_d = zps_pkg::ST_LOAD_WB;
      zps_pkg::ST_LOAD_WB:    state_d = zps_pkg::ST_FINISH;
      zps_pkg::ST_MEM_WR:     state_d = zps_pkg::ST_FINISH;
      zps_pkg::ST_MEM_RD:     state_d = zps_pkg::ST_MEM_RD_WB;
      zps_pkg::ST_MEM_RD_WB:  state_d = zps_pkg::ST_FINISH;
      zps_pkg::ST_FINISH: begin
        if (sts_i.out_free) begin
          state_d = zps_pkg::ST_IDLE;
        end
      end
      default: state_d = zps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      zps_pkg::ST_IDLE:       cmd_o.latch_in = accept;
      zps_pkg::ST_FETCH:      cmd_o.rd_pc    = 1'b1;
      zps_pkg::ST_DECODE:     cmd_o.exec     = 1'b1;
      zps_pkg::ST_OPND_LO:    cmd_o.rd_pc    = 1'b1;
      zps_pkg::ST_OPND_LO_WB: begin
        cmd_o.take_lo = 1'b1;
        cmd_o.rd_pc   = (cls_q == zps_pkg::CLS_IMM16);
      end
      zps_pkg::ST_OPND_HI_WB: cmd_o.take_hi  = 1'b1;
      zps_pkg::ST_STORE:      cmd_o.wr_bc    = 1'b1;
      zps_pkg::ST_LOAD:       cmd_o.rd_bc    = 1'b1;
      zps_pkg::ST_LOAD_WB:    cmd_o.take_ld  = 1'b1;
      zps_pkg::ST_MEM_WR:     cmd_o.wr_addr  = 1'b1;
      zps_pkg::ST_MEM_RD:     cmd_o.rd_addr  = 1'b1;
      zps_pkg::ST_MEM_RD_WB:  cmd_o.take_rd  = 1'b1;
      zps_pkg::ST_FINISH:     cmd_o.load_out = sts_i.out_free;
      default:                cmd_o = '0;
    endcase
  end

endmodule

// ===== src/zps_dp.sv =====
module zps_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  zps_pkg::zps_cmd_t cmd_i,
  input  logic [1:0]        in_cmd_i,
  input  logic [15:0]       address_i,
  input  logic [7:0]        write_data_i,
  input  logic              out_stall_i,
  output zps_pkg::zps_sts_t sts_o,
  output logic              out_valid_o,
  output logic [7:0]        read_data_o,
  output logic [7:0]        opcode_o,
  output logic [15:0]       pc_value_o,
  output logic [15:0]       af_value_o,
  output logic [15:0]       bc_value_o,
  output logic [15:0]       hl_value_o,
  output logic [15:0]       af_alt_value_o,
  output logic [15:0]       wz_value_o,
  output logic              halted_o,
  output logic [31:0]       tact_count_o
);

  localparam int unsigned MemDepth = 2 ** zps_pkg::ADDR_W;

  logic [7:0]  mem [MemDepth];
  logic [7:0]  mem_rdata_q;
  logic [zps_pkg::ADDR_W-1:0] mem_addr;
  logic [7:0]  mem_wdata;
  logic        mem_we, mem_re;

  logic [15:0] af_q, af_d, bc_q, bc_d, hl_q, hl_d, af_alt_q, af_alt_d;
  logic [15:0] wz_q, wz_d, pc_q, pc_d;
  logic [31:0] tact_q, tact_d;
  logic        halt_q, halt_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [7:0]  lo_q, lo_d;
  logic [7:0]  rd_q, rd_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  wdata_q, wdata_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_rd_q, out_op_q;
  logic [15:0] out_pc_q, out_af_q, out_bc_q, out_hl_q, out_af_alt_q, out_wz_q;
  logic        out_halt_q;
  logic [31:0] out_tact_q;

  logic [7:0]  acc, flg, op, unit_in, inc_r, dec_r, inc_f, dec_f, rlc_r, rrc_r;
  logic [16:0] sum;
  logic [12:0] half_sum;

  assign acc = af_q[15:8];
  assign flg = af_q[7:0];
  assign op  = mem_rdata_q;

  assign unit_in = (op == zps_pkg::OP_INC_C || op == zps_pkg::OP_DEC_C) ? bc_q[7:0] : bc_q[15:8];
  assign inc_r   = unit_in + 8'd1;
  assign dec_r   = unit_in - 8'd1;
  assign inc_f   = (flg & zps_pkg::F_C) | (inc_r & zps_pkg::F_SXY)
                 | ((inc_r == 8'h00) ? zps_pkg::F_Z : 8'h00)
                 | ((unit_in[3:0] == 4'hf) ? zps_pkg::F_H : 8'h00)
                 | ((unit_in == 8'h7f) ? zps_pkg::F_PV : 8'h00);
  assign dec_f   = (flg & zps_pkg::F_C) | zps_pkg::F_N | (dec_r & zps_pkg::F_SXY)
                 | ((dec_r == 8'h00) ? zps_pkg::F_Z : 8'h00)
                 | ((unit_in[3:0] == 4'h0) ? zps_pkg::F_H : 8'h00)
                 | ((unit_in == 8'h80) ? zps_pkg::F_PV : 8'h00);
  assign rlc_r   = {acc[6:0], acc[7]};
  assign rrc_r   = {acc[0], acc[7:1]};
  assign sum      = {1'b0, hl_q} + {1'b0, bc_q};
  assign half_sum = {1'b0, hl_q[11:0]} + {1'b0, bc_q[11:0]};

  assign mem_we    = cmd_i.wr_bc || cmd_i.wr_addr;
  assign mem_re    = cmd_i.rd_pc || cmd_i.rd_bc || cmd_i.rd_addr;
  assign mem_wdata = cmd_i.wr_bc ? acc : wdata_q;
  always_comb begin
    if (cmd_i.rd_pc) begin
      mem_addr = pc_q;
    end else if (cmd_i.rd_bc || cmd_i.wr_bc) begin
      mem_addr = bc_q;
    end else begin
      mem_addr = addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_addr];
    end
  end

  always_comb begin
    af_d     = af_q;
    bc_d     = bc_q;
    hl_d     = hl_q;
    af_alt_d = af_alt_q;
    wz_d     = wz_q;
    pc_d     = pc_q;
    tact_d   = tact_q;
    halt_d   = halt_q;
    opcode_d = opcode_q;
    lo_d     = lo_q;
    rd_d     = rd_q;
    addr_d   = addr_q;
    wdata_d  = wdata_q;
    if (cmd_i.latch_in) begin
      addr_d  = address_i;
      wdata_d = write_data_i;
      rd_d    = 8'h00;
      if (in_cmd_i == zps_pkg::CMD_EXEC && halt_q) begin
        tact_d = tact_q + 32'd4;
      end
    end
    if (cmd_i.rd_pc) begin
      pc_d = pc_q + 16'd1;
    end
    if (cmd_i.exec) begin
      opcode_d = op;
      tact_d   = tact_q + 32'(zps_pkg::op_cost(op));
      case (op)
        zps_pkg::OP_NOP, zps_pkg::OP_LD_BC_NN, zps_pkg::OP_LD_B_N,
        zps_pkg::OP_LD_C_N, zps_pkg::OP_LD_HL_NN, zps_pkg::OP_LD_A_N: begin
        end
        zps_pkg::OP_LD_IBC_A: wz_d = {acc, bc_q[7:0] + 8'd1};
        zps_pkg::OP_LD_A_IBC: wz_d = bc_q + 16'd1;
        zps_pkg::OP_INC_BC:   bc_d = bc_q + 16'd1;
        zps_pkg::OP_DEC_BC:   bc_d = bc_q - 16'd1;
        zps_pkg::OP_INC_B: begin
          bc_d = {inc_r, bc_q[7:0]};
          af_d = {acc, inc_f};
        end
        zps_pkg::OP_DEC_B: begin
          bc_d = {dec_r, bc_q[7:0]};
          af_d = {acc, dec_f};
        end
        zps_pkg::OP_INC_C: begin
          bc_d = {bc_q[15:8], inc_r};
          af_d = {acc, inc_f};
        end
        zps_pkg::OP_DEC_C: begin
          bc_d = {bc_q[15:8], dec_r};
          af_d = {acc, dec_f};
        end
        zps_pkg::OP_RLCA: begin
          af_d = {rlc_r, (flg & zps_pkg::F_SZPV) | (rlc_r & zps_pkg::F_XY) | {7'd0, acc[7]}};
        end
        zps_pkg::OP_RRCA: begin
          af_d = {rrc_r, (flg & zps_pkg::F_SZPV) | (rrc_r & zps_pkg::F_XY) | {7'd0, acc[0]}};
        end
        zps_pkg::OP_EX_AF: begin
          af_d     = af_alt_q;
          af_alt_d = af_q;
        end
        zps_pkg::OP_ADD_HLBC: begin
          wz_d = hl_q + 16'd1;
          hl_d = sum[15:0];
          af_d = {acc, (flg & zps_pkg::F_SZPV) | (sum[15:8] & zps_pkg::F_XY)
                       | (half_sum[12] ? zps_pkg::F_H : 8'h00) | {7'd0, sum[16]}};
        end
        default: halt_d = 1'b1;
      endcase
    end
    if (cmd_i.take_lo) begin
      case (opcode_q)
        zps_pkg::OP_LD_B_N: bc_d = {op, bc_q[7:0]};
        zps_pkg::OP_LD_C_N: bc_d = {bc_q[15:8], op};
        zps_pkg::OP_LD_A_N: af_d = {op, flg};
        default:            lo_d = op;
      endcase
    end
    if (cmd_i.take_hi) begin
      if (opcode_q == zps_pkg::OP_LD_HL_NN) begin
        hl_d = {op, lo_q};
      end else begin
        bc_d = {op, lo_q};
      end
    end
    if (cmd_i.take_ld) begin
      af_d = {op, flg};
    end
    if (cmd_i.take_rd) begin
      rd_d = op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      af_q        <= 16'hffff;
      bc_q        <= '0;
      hl_q        <= '0;
      af_alt_q    <= 16'hffff;
      wz_q        <= '0;
      pc_q        <= '0;
      tact_q      <= '0;
      halt_q      <= 1'b0;
      opcode_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      af_q        <= af_d;
      bc_q        <= bc_d;
      hl_q        <= hl_d;
      af_alt_q    <= af_alt_d;
      wz_q        <= wz_d;
      pc_q        <= pc_d;
      tact_q      <= tact_d;
      halt_q      <= halt_d;
      opcode_q    <= opcode_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    rd_q    <= rd_d;
    addr_q  <= addr_d;
    wdata_q <= wdata_d;
    if (cmd_i.load_out) begin
      out_rd_q     <= rd_q;
      out_op_q     <= opcode_q;
      out_pc_q     <= pc_q;
      out_af_q     <= af_q;
      out_bc_q     <= bc_q;
      out_hl_q     <= hl_q;
      out_af_alt_q <= af_alt_q;
      out_wz_q     <= wz_q;
      out_halt_q   <= halt_q;
      out_tact_q   <= tact_q;
    end
  end

  assign out_valid_d    = cmd_i.load_out || (out_valid_q && out_stall_i);
  assign sts_o.halted   = halt_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.cls      = zps_pkg::op_class(op);

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_rd_q;
  assign opcode_o       = out_op_q;
  assign pc_value_o     = out_pc_q;
  assign af_value_o     = out_af_q;
  assign bc_value_o     = out_bc_q;
  assign hl_value_o     = out_hl_q;
  assign af_alt_value_o = out_af_alt_q;
  assign wz_value_o     = out_wz_q;
  assign halted_o       = out_halt_q;
  assign tact_count_o   = out_tact_q;

endmodule

// ===== src/z80_partial_instruction_step_unit.sv =====
// An accepted word goes straight to the finish state for the unused command or a halted step,
// via the write state for a write, the read and writeback states for a read, and fetch,
// decode, then any operand reads, store or load of A for an instruction. Memory is single-port:
// fetch, operand reads and data access use it one per cycle. One word is in work at a time;
// the next is taken in the idle state after its result is registered. Reset gives AF and AF'
// 0xffff and clears BC, HL, WZ, PC, the tact count, halt and opcode; memory is undefined until written.
module z80_partial_instruction_step_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic [7:0]  opcode_o,
  output logic [15:0] pc_value_o,
  output logic [15:0] af_value_o,
  output logic [15:0] bc_value_o,
  output logic [15:0] hl_value_o,
  output logic [15:0] af_alt_value_o,
  output logic [15:0] wz_value_o,
  output logic        halted_o,
  output logic [31:0] tact_count_o
);

  zps_pkg::zps_cmd_t cmd;
  zps_pkg::zps_sts_t sts;

  zps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  zps_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_cmd_i       (cmd_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .out_stall_i    (out_stall_i),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .read_data_o    (read_data_o),
    .opcode_o       (opcode_o),
    .pc_value_o     (pc_value_o),
    .af_value_o     (af_value_o),
    .bc_value_o     (bc_value_o),
    .hl_value_o     (hl_value_o),
    .af_alt_value_o (af_alt_value_o),
    .wz_value_o     (wz_value_o),
    .halted_o       (halted_o),
    .tact_count_o   (tact_count_o)
  );

endmodule
